// ===== src/lhp_pkg.sv =====
// Shared types, constants and codes of the RGB and luma histogram block.
package lhp_pkg;

	// Histogram geometry: four channels of 256 bins
	localparam int NUM_CH   = 4;
	localparam int CH_W     = 2;
	localparam int NUM_BINS = 256;
	localparam int BIN_W    = 8;
	localparam int WALK_W   = CH_W + BIN_W;

	// Bin count width and the rank reported by a finish walk
	localparam int CNT_W = 24;
	localparam int RANK  = 6;

	// Rec.709 luma weights in Q16, with the rounding half
	localparam logic [15:0] COEF_R    = 16'd13933;
	localparam logic [15:0] COEF_G    = 16'd46871;
	localparam logic [15:0] COEF_B    = 16'd4732;
	localparam logic [23:0] LUMA_HALF = 24'd32768;

	// Channel numbers
	localparam logic [CH_W-1:0] CH_RED   = 2'd0;
	localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
	localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;
	localparam logic [CH_W-1:0] CH_LUMA  = 2'd3;

	// Result kinds
	localparam logic KIND_REF = 1'b0;
	localparam logic KIND_BIN = 1'b1;

	// Register word index of the stride register
	localparam logic REG_STRIDE = 1'b0;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_PIXEL  = 2'd1,
		OP_FINISH = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_WALK,
		ST_DRAIN,
		ST_EMIT_REF,
		ST_BIN_RD,
		ST_EMIT_BIN
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic clr_step;
		logic pix_rd;
		logic pix_wr;
		logic walk_rd;
		logic bin_rd;
		logic emit_ref;
		logic emit_bin;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic walk_last;
		logic out_free;
	} sts_t;

endpackage

// ===== src/lhp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lhp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/lhp_ctrl.sv =====
// Controller state machine that sequences clear, pixel, walk and read work.
module lhp_ctrl import lhp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  op_t    op,
	input  sts_t   sts,
	output logic   in_ready,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register; reset enters the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (op)
						OP_START:  state_nxt = ST_CLEAR;
						OP_PIXEL:  state_nxt = ST_PIX_RD;
						OP_FINISH: state_nxt = ST_WALK;
						OP_READ:   state_nxt = ST_BIN_RD;
						default:   state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_PIX_RD:  state_nxt = ST_PIX_WR;
			ST_PIX_WR:  state_nxt = ST_IDLE;
			ST_WALK: begin
				if (sts.walk_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN:   state_nxt = ST_EMIT_REF;
			ST_EMIT_REF: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_BIN_RD:  state_nxt = ST_EMIT_BIN;
			ST_EMIT_BIN: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_CLEAR:    cmd.clr_step = 1'b1;
			ST_PIX_RD:   cmd.pix_rd   = 1'b1;
			ST_PIX_WR:   cmd.pix_wr   = 1'b1;
			ST_WALK:     cmd.walk_rd  = 1'b1;
			ST_DRAIN:    cmd          = '0;
			ST_EMIT_REF: cmd.emit_ref = sts.out_free;
			ST_BIN_RD:   cmd.bin_rd   = 1'b1;
			ST_EMIT_BIN: cmd.emit_bin = sts.out_free;
			default:     cmd          = '0;
		endcase
	end

endmodule

// ===== src/lhp_dp.sv =====
// Datapath: bin stores, phase counters, luma, top-count list and result register.
module lhp_dp import lhp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  op_t              op,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	input  logic             row_end,
	input  logic [CH_W-1:0]  channel,
	input  logic [BIN_W-1:0] bin,
	input  logic [7:0]       stride,
	input  logic             out_ready,
	output sts_t             sts,
	output logic             out_valid,
	output logic             out_kind,
	output logic [CNT_W-1:0] out_value
);

	logic [7:0]        col_q;
	logic [7:0]        row_q;
	logic              count_q;
	logic [7:0]        red_q;
	logic [7:0]        green_q;
	logic [7:0]        blue_q;
	logic [CH_W-1:0]   chan_q;
	logic [BIN_W-1:0]  bin_q;
	logic [BIN_W-1:0]  luma_q;
	logic [BIN_W-1:0]  clr_idx_q;
	logic [WALK_W-1:0] walk_idx_q;
	logic [CH_W-1:0]   walk_ch_s1;
	logic              ins_vld_s1;
	logic [CNT_W-1:0]  top_q [RANK];
	logic [CNT_W-1:0]  top_nxt [RANK];
	logic              gt [RANK];
	logic              out_vld_q;
	logic              out_kind_q;
	logic [CNT_W-1:0]  out_val_q;

	logic [8:0]        stride_w;
	logic [8:0]        col_inc;
	logic [8:0]        row_inc;
	logic [23:0]       luma_sum;
	logic [BIN_W-1:0]  luma_now;
	logic [BIN_W-1:0]  com_addr;
	logic [BIN_W-1:0]  rd_addr [NUM_CH];
	logic [BIN_W-1:0]  wr_addr [NUM_CH];
	logic [CNT_W-1:0]  wr_data [NUM_CH];
	logic [CNT_W-1:0]  rdata [NUM_CH];
	logic              ram_we;
	logic              ram_re;
	logic [CH_W-1:0]   rd_sel;
	logic [CNT_W-1:0]  sel_data;
	logic [CNT_W-1:0]  ref_level;

	// Luma of the held pixel, rounded Q16 weighted sum
	assign luma_sum = (24'(COEF_R) * 24'(red_q)) + (24'(COEF_G) * 24'(green_q)) +
		(24'(COEF_B) * 24'(blue_q)) + LUMA_HALF;
	assign luma_now = luma_sum[23:16];

	assign stride_w = {1'b0, stride};
	assign col_inc  = {1'b0, col_q} + 9'd1;
	assign row_inc  = {1'b0, row_q} + 9'd1;

	// Phase counters and the sample decision, updated on each pixel transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= 1'b0;
		end else if (cmd.accept) begin
			if (op == OP_START) begin
				col_q <= '0;
				row_q <= '0;
			end else if (op == OP_PIXEL) begin
				count_q <= (col_q == '0) && (row_q == '0);
				if (row_end) begin
					col_q <= '0;
					row_q <= (row_inc >= stride_w) ? '0 : row_inc[7:0];
				end else begin
					col_q <= (col_inc >= stride_w) ? '0 : col_inc[7:0];
				end
			end
		end
	end

	// Hold the item fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
			chan_q  <= channel;
			bin_q   <= bin;
		end
		if (cmd.pix_rd) begin
			luma_q <= luma_now;
		end
	end

	// Clear and walk address counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			walk_idx_q <= '0;
			walk_ch_s1 <= '0;
			ins_vld_s1 <= 1'b0;
		end else begin
			if (cmd.accept && op == OP_START) begin
				clr_idx_q <= '0;
			end else if (cmd.clr_step) begin
				clr_idx_q <= clr_idx_q + BIN_W'(1);
			end
			if (cmd.accept && op == OP_FINISH) begin
				walk_idx_q <= '0;
			end else if (cmd.walk_rd) begin
				walk_idx_q <= walk_idx_q + WALK_W'(1);
			end
			walk_ch_s1 <= walk_idx_q[WALK_W-1:BIN_W];
			ins_vld_s1 <= cmd.walk_rd;
		end
	end

	assign sts.clr_last  = (clr_idx_q == '1);
	assign sts.walk_last = (walk_idx_q == '1);
	assign sts.out_free  = !out_vld_q || out_ready;

	// Store addressing: own bin per channel for pixels, shared bin otherwise
	assign com_addr = cmd.walk_rd ? walk_idx_q[BIN_W-1:0] : bin_q;
	assign ram_re   = cmd.pix_rd || cmd.walk_rd || cmd.bin_rd;
	assign ram_we   = cmd.clr_step || (cmd.pix_wr && count_q);

	always_comb begin
		wr_addr[CH_RED]   = red_q;
		wr_addr[CH_GREEN] = green_q;
		wr_addr[CH_BLUE]  = blue_q;
		wr_addr[CH_LUMA]  = luma_q;
		for (int c = 0; c < NUM_CH; c++) begin
			rd_addr[c] = com_addr;
			if (cmd.pix_rd) begin
				rd_addr[c] = wr_addr[c];
			end
		end
		rd_addr[CH_LUMA] = cmd.pix_rd ? luma_now : com_addr;
	end

	// One store per channel; saturating increment on write back
	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		assign wr_data[c] = cmd.clr_step ? '0 :
			((rdata[c] == '1) ? rdata[c] : rdata[c] + CNT_W'(1));

		lhp_ram #(
			.WIDTH (CNT_W),
			.DEPTH (NUM_BINS)
		) u_ram (
			.clk   (clk),
			.we    (ram_we),
			.waddr (cmd.clr_step ? clr_idx_q : wr_addr[c]),
			.wdata (wr_data[c]),
			.re    (ram_re),
			.raddr (rd_addr[c]),
			.rdata (rdata[c])
		);
	end

	assign rd_sel   = ins_vld_s1 ? walk_ch_s1 : chan_q;
	assign sel_data = rdata[rd_sel];

	// Insert one count into the descending list of largest counts
	for (genvar k = 0; k < RANK; k++) begin : g_ins
		assign gt[k] = sel_data > top_q[k];
		if (k == 0) begin : g_first
			assign top_nxt[k] = gt[k] ? sel_data : top_q[k];
		end else begin : g_rest
			assign top_nxt[k] = !gt[k] ? top_q[k] :
				(gt[k-1] ? top_q[k-1] : sel_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RANK; k++) begin
				top_q[k] <= '0;
			end
		end else if (cmd.accept && (op == OP_START || op == OP_FINISH)) begin
			for (int k = 0; k < RANK; k++) begin
				top_q[k] <= '0;
			end
		end else if (ins_vld_s1) begin
			for (int k = 0; k < RANK; k++) begin
				top_q[k] <= top_nxt[k];
			end
		end
	end

	assign ref_level = (top_q[RANK-1] == '0) ? CNT_W'(1) : top_q[RANK-1];

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit_ref || cmd.emit_bin) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ref) begin
			out_kind_q <= KIND_REF;
			out_val_q  <= ref_level;
		end else if (cmd.emit_bin) begin
			out_kind_q <= KIND_BIN;
			out_val_q  <= sel_data;
		end
	end

	assign out_valid = out_vld_q;
	assign out_kind  = out_kind_q;
	assign out_value = out_val_q;

endmodule

// ===== src/rgb_luma_histogram_percentile.sv =====
// Top level of the RGB and Rec.709 luma histogram with percentile reference level.
//
// Items arrive on the s_ stream: tuser carries the opcode and read channel, tdata the
// pixel components and read bin, tlast marks the last pixel of a row. Results leave on
// the m_ stream: tuser is the result kind, tdata the 24-bit level or bin count.
// The APB port holds the sample stride (word 0, reset 1).
// One item is taken at a time; the four channel stores each have one read and one
// write port, and each item runs these steps:
//   pixel  : read, saturating write back when the pixel is sampled
//   start  : a clearing pass over all bins of the four stores
//   finish : a walk of one bin per cycle through the six-deep top list, then the
//            result register takes the reference level
//   read   : a bin read, then the result register takes the bin count
// After reset the same clearing pass runs and s_tready stays low; stride
// writes are taken throughout. The result register lets the next item in while a
// result waits; an item that needs a result holds until the receiver takes the
// previous one.
module rgb_luma_histogram_percentile import lhp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], bin[31:24]
	input  logic [3:0]  s_tuser,   // opcode[1:0], channel[3:2]
	input  logic        s_tlast,
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // value[23:0]
	output logic [0:0]  m_tuser,   // result_kind[0]
	// Register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] stride_q;
	logic       cfg_wr;
	cmd_t       cmd;
	sts_t       sts;
	op_t        op;

	// Stride register, written on the access cycle of a transfer
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_STRIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= 8'd1;
		end else if (cfg_wr) begin
			stride_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_STRIDE) ? {24'd0, stride_q} : '0;

	assign op = op_t'(s_tuser[1:0]);

	lhp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.op       (op),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	lhp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (op),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.row_end   (s_tlast),
		.channel   (s_tuser[3:2]),
		.bin       (s_tdata[31:24]),
		.stride    (stride_q),
		.out_ready (m_tready),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_kind  (m_tuser[0]),
		.out_value (m_tdata)
	);

endmodule
